/* hw/rtl/assert_macros.svh */
// shared assertion macros, sampled on clock and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define MM_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// same-cycle implication check
`define MM_ASSERT_IMP(name, ante, cons, msg) \
   `MM_ASSERT(name, (ante) |-> (cons), msg)

`endif

/* hw/rtl/mm_pkg.sv */
`timescale 1ns / 1ps

package mm_pkg;

   // default sizes
   localparam int MM_MAX_DIM    = 8;
   localparam int MM_ELEM_WIDTH = 16;

   // fixed field widths
   localparam int CMD_W        = 2;
   localparam int ELEM_INDEX_W = 6;
   localparam int ELEM_VALUE_W = 16;
   localparam int VALUE_W      = 40;
   localparam int ROW_W        = 3;
   localparam int CFG_W        = 4;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_COUNT    = 4;

   // stream payload layout
   localparam int REQ_DATA_W   = 24;
   localparam int RSP_DATA_W   = 48;
   localparam int REQ_INDEX_LO = 0;
   localparam int REQ_VALUE_LO = ELEM_INDEX_W;
   localparam int RSP_ROW_LO   = VALUE_W;
   localparam int RSP_COL_LO   = VALUE_W + ROW_W;
   localparam int RSP_PAD_W    = RSP_DATA_W - VALUE_W - 2 * ROW_W;

   // reset value of every dimension register
   localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

   // command codes carried on req_tuser
   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE_A = 2'd0,
      CMD_WRITE_B = 2'd1,
      CMD_COMPUTE = 2'd2
   } cmd_code_type;

   // register indexes on the csr channel
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS_A = 2'd0,
      CSR_COLS_A = 2'd1,
      CSR_ROWS_B = 2'd2,
      CSR_COLS_B = 2'd3
   } csr_index_type;

   // result status codes
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_MISMATCH = 1'b1;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ERROR,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_a;
      logic load_b;
      logic clear;
      logic read;
      logic emit;
      logic emit_err;
      logic advance;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic mismatch;
      logic k_last;
      logic elem_last;
      logic pipe_busy;
      logic out_busy;
   } dp_status_type;

endpackage

/* hw/rtl/mm_ctrl.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mm_ctrl
   import mm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [CMD_W-1:0]  req_tuser,
   input  dp_status_type     status,
   output dp_cmd_type        cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && (req_tuser == CMD_COMPUTE)) begin
               state_in = status.mismatch ? ST_ERROR : ST_ISSUE;
            end
         end
         ST_ERROR: begin
            if (!status.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         ST_ISSUE: begin
            if (status.k_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy && !status.out_busy) begin
               state_in = status.elem_last ? ST_IDLE : ST_ISSUE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (req_tuser)
                  CMD_WRITE_A: cmd.load_a = 1'b1;
                  CMD_WRITE_B: cmd.load_b = 1'b1;
                  CMD_COMPUTE: cmd.clear  = !status.mismatch;
                  default:     cmd        = '0;
               endcase
            end
         end
         ST_ERROR: begin
            cmd.emit_err = !status.out_busy;
         end
         ST_ISSUE: begin
            cmd.read = 1'b1;
         end
         ST_DRAIN: begin
            if (!status.pipe_busy && !status.out_busy) begin
               cmd.emit    = 1'b1;
               cmd.advance = 1'b1;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // checks
   `MM_ASSERT_IMP(a_emit_free, cmd.emit || cmd.emit_err, !status.out_busy, "result overwritten")
   `MM_ASSERT_IMP(a_emit_drained, cmd.emit, !status.pipe_busy, "emit before sum complete")
   `MM_ASSERT_IMP(a_err_mismatch, cmd.emit_err, status.mismatch, "error without mismatch")

endmodule

/* hw/rtl/mm_datapath.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mm_datapath
   import mm_pkg::*;
#(
   parameter int MAX_DIM    = MM_MAX_DIM,
   parameter int ELEM_WIDTH = MM_ELEM_WIDTH
)
(
   input  logic                   clock,
   input  logic                   reset,
   // configuration writes
   input  logic                   csr_valid,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CFG_W-1:0]       csr_data,
   // load payload
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic                   rsp_tuser,
   output logic                   rsp_tlast,
   // control
   input  dp_cmd_type             cmd,
   output dp_status_type          status
);

   localparam int DEPTH     = MAX_DIM * MAX_DIM;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int DIM_W     = $clog2(MAX_DIM + 1);
   localparam int IDX_W     = $clog2(MAX_DIM);
   localparam int PROD_W    = 2 * ELEM_WIDTH;
   localparam int IDX_CMP_W = ELEM_INDEX_W + 1;

   // dimension registers and their saturated values
   logic [CFG_W-1:0] cfg_ff [CSR_COUNT];
   logic [DIM_W-1:0] dim [CSR_COUNT];
   logic [DIM_W-1:0] ra_m1;
   logic [DIM_W-1:0] ca_m1;
   logic [DIM_W-1:0] cb_m1;

   // operand stores
   logic [ELEM_WIDTH-1:0] mem_a [DEPTH];
   logic [ELEM_WIDTH-1:0] mem_b [DEPTH];

   // load fields
   logic [ELEM_INDEX_W-1:0]        elem_index;
   logic signed [ELEM_VALUE_W-1:0] elem_value;
   logic [ELEM_WIDTH-1:0]          elem_ext;
   logic                           index_ok;
   logic [ADDR_W-1:0]              waddr;

   // loop counters and addresses
   logic [IDX_W-1:0]  i_ff, i_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [IDX_W-1:0]  k_ff, k_in;
   logic [ADDR_W-1:0] base_a_ff, base_a_in;
   logic [ADDR_W-1:0] addr_b_ff, addr_b_in;
   logic              i_last;
   logic              j_last;

   // multiply-accumulate pipe
   logic signed [ELEM_WIDTH-1:0] rd_a_ff;
   logic signed [ELEM_WIDTH-1:0] rd_b_ff;
   logic                         rd_vld_ff;
   logic signed [PROD_W-1:0]     prod_ff;
   logic signed [PROD_W-1:0]     prod_in;
   logic                         prod_vld_ff;
   logic [VALUE_W-1:0]           acc_ff, acc_in;

   // result register
   logic               rsp_valid_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [ROW_W-1:0]   row_ff;
   logic [ROW_W-1:0]   col_ff;
   logic               status_ff;
   logic               last_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < CSR_COUNT; r++) begin
            cfg_ff[r] <= CFG_RESET;
         end
      end else if (csr_valid) begin
         cfg_ff[csr_index] <= csr_data;
      end
   end

   // clamp each dimension into 1..MAX_DIM
   always_comb begin
      for (int r = 0; r < CSR_COUNT; r++) begin
         if (cfg_ff[r] == '0) begin
            dim[r] = DIM_W'(1);
         end else if (cfg_ff[r] > CFG_W'(MAX_DIM)) begin
            dim[r] = DIM_W'(MAX_DIM);
         end else begin
            dim[r] = DIM_W'(cfg_ff[r]);
         end
      end
   end

   assign ra_m1 = dim[CSR_ROWS_A] - DIM_W'(1);
   assign ca_m1 = dim[CSR_COLS_A] - DIM_W'(1);
   assign cb_m1 = dim[CSR_COLS_B] - DIM_W'(1);

   // load decode, value narrowed or sign extended to the store width
   assign elem_index = req_tdata[REQ_INDEX_LO +: ELEM_INDEX_W];
   assign elem_value = req_tdata[REQ_VALUE_LO +: ELEM_VALUE_W];
   assign elem_ext   = ELEM_WIDTH'(elem_value);
   assign index_ok   = ({1'b0, elem_index} < IDX_CMP_W'(DEPTH));
   assign waddr      = elem_index[ADDR_W-1:0];

   // store writes
   always_ff @(posedge clock) begin
      if (cmd.load_a && index_ok) begin
         mem_a[waddr] <= elem_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_b && index_ok) begin
         mem_b[waddr] <= elem_ext;
      end
   end

   // store reads, a at row base plus k, b at k*cols_b plus j
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_a_ff <= mem_a[base_a_ff + ADDR_W'(k_ff)];
         rd_b_ff <= mem_b[addr_b_ff];
      end
   end

   // counter next values
   assign i_last = (i_ff == IDX_W'(ra_m1));
   assign j_last = (j_ff == IDX_W'(cb_m1));

   always_comb begin
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      base_a_in = base_a_ff;
      addr_b_in = addr_b_ff;
      if (cmd.clear) begin
         i_in      = '0;
         j_in      = '0;
         k_in      = '0;
         base_a_in = '0;
         addr_b_in = '0;
      end else if (cmd.read) begin
         k_in      = k_ff + IDX_W'(1);
         addr_b_in = addr_b_ff + ADDR_W'(dim[CSR_COLS_B]);
      end else if (cmd.advance) begin
         k_in = '0;
         if (j_last) begin
            j_in      = '0;
            i_in      = i_ff + IDX_W'(1);
            base_a_in = base_a_ff + ADDR_W'(dim[CSR_COLS_A]);
            addr_b_in = '0;
         end else begin
            j_in      = j_ff + IDX_W'(1);
            addr_b_in = ADDR_W'(j_ff) + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
      base_a_ff <= base_a_in;
      addr_b_ff <= addr_b_in;
   end

   // product stage, then accumulate modulo the result width
   assign prod_in = rd_a_ff * rd_b_ff;

   always_comb begin
      acc_in = acc_ff;
      if (cmd.clear || cmd.advance) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + VALUE_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= cmd.read;
         prod_vld_ff <= rd_vld_ff;
      end
   end

   // result register, refilled only when empty or being taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit || cmd.emit_err) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_err) begin
         value_ff  <= '0;
         row_ff    <= '0;
         col_ff    <= '0;
         status_ff <= STATUS_MISMATCH;
         last_ff   <= 1'b1;
      end else if (cmd.emit) begin
         value_ff  <= acc_ff;
         row_ff    <= ROW_W'(i_ff);
         col_ff    <= ROW_W'(j_ff);
         status_ff <= STATUS_OK;
         last_ff   <= i_last && j_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, col_ff, row_ff, value_ff};
   assign rsp_tuser  = status_ff;
   assign rsp_tlast  = last_ff;

   // status toward the controller
   assign status.mismatch  = (dim[CSR_COLS_A] != dim[CSR_ROWS_B]);
   assign status.k_last    = (k_ff == IDX_W'(ca_m1));
   assign status.elem_last = i_last && j_last;
   assign status.pipe_busy = rd_vld_ff || prod_vld_ff;
   assign status.out_busy  = rsp_valid_ff && !rsp_tready;

   // checks
   `MM_ASSERT_IMP(a_err_is_last, rsp_tvalid && rsp_tuser, rsp_tlast, "error result not last")
   `MM_ASSERT_IMP(a_pipe_order, prod_vld_ff, $past(rd_vld_ff), "product without read data")
   `MM_ASSERT_IMP(a_k_range, cmd.read, k_ff <= IDX_W'(ca_m1), "inner index past cols_a")

endmodule

/* hw/rtl/matrix_multiply.sv */
// channel   dir   handshake                fields, low bit first
// req       in    req_tvalid/req_tready    tuser: cmd; tdata: elem_index, elem_value
// rsp       out   rsp_tvalid/rsp_tready    tuser: status; tlast: last;
//                                          tdata: product_value, out_row, out_col
// csr       in    csr_valid/csr_ready      csr_index, csr_data
//
// a compute holds req_tready low after its first cycle; it runs on one shared
// multiply-accumulate unit that reads one element of each store per cycle, and
// each result element then drains through store read, product register and accumulate.
// a stalled result holds the sequencer.
// reset is synchronous; the stores hold no reset and need no clearing pass.
`timescale 1ns / 1ps

module matrix_multiply
   import mm_pkg::*;
#(
   parameter int MAX_DIM    = MM_MAX_DIM,
   parameter int ELEM_WIDTH = MM_ELEM_WIDTH
)
(
   input  logic                   clock,
   input  logic                   reset,
   // request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // elem_index, elem_value, zero pad
   input  logic [CMD_W-1:0]       req_tuser,   // cmd
   // result stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // product_value, out_row, out_col, zero pad
   output logic                   rsp_tuser,   // status
   output logic                   rsp_tlast,
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CFG_W-1:0]       csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // registers are always writable
   assign csr_ready = 1'b1;

   mm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   mm_datapath #(
      .MAX_DIM    (MAX_DIM),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
